[sv/tri_rc_pkg.sv]
// ----------------------------------------------------------------------------
// tri_rc_pkg
// Shared widths and the pipeline word type for the triangular index unit.
// ----------------------------------------------------------------------------
package tri_rc_pkg;

  // linear index width
  localparam int IDX_W  = 20;
  // matrix size register width, also holds any column or row number
  localparam int SIZE_W = 11;
  // width of the row and column result ports
  localparam int OUT_W  = 10;
  // width of a column start index or of the element count
  localparam int SUM_W  = 21;
  // largest size the size register can hold
  localparam int SIZE_MAX = 2047;

  // one word moving down the pipeline
  typedef struct packed {
    logic              valid;
    logic              err;
    logic [IDX_W-1:0]  idx;
    logic [SIZE_W-1:0] n;
    logic [SIZE_W-1:0] col;
    logic [SUM_W-1:0]  start;
  } item_t;

endpackage

[sv/tri_rc_front.sv]
// ----------------------------------------------------------------------------
// tri_rc_front
// Size register, element count, and the entry stage with the range check.
// ----------------------------------------------------------------------------
module tri_rc_front
  import tri_rc_pkg::*;
#(
  parameter int MAX_ROWS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] matrix_size,
  input  logic              accept,
  input  logic [IDX_W-1:0]  linear_index,
  output item_t             item
);

  localparam int SAT = (MAX_ROWS < SIZE_MAX) ? MAX_ROWS : SIZE_MAX;

  logic [SIZE_W-1:0]   size;
  logic [SIZE_W-1:0]   eff_n;
  logic [SUM_W-1:0]    total;
  logic [2*SIZE_W-1:0] pairs;

  // hold the configured size
  always_ff @(posedge clk) begin
    if (rst) begin
      size <= SIZE_W'(2);
    end else if (cfg_wr_en) begin
      size <= matrix_size;
    end
  end

  // saturate the size to the supported row count
  assign eff_n = (size > SIZE_W'(SAT)) ? SIZE_W'(SAT) : size;
  assign pairs = eff_n * (eff_n - SIZE_W'(1));

  // element count of the current size, valid right after a size write
  assign total = (eff_n < SIZE_W'(2)) ? '0 : pairs[SUM_W:1];

  // capture the word and flag indexes past the triangle
  always_ff @(posedge clk) begin
    if (rst) begin
      item.valid <= 1'b0;
    end else begin
      item.valid <= accept;
    end
    item.idx   <= linear_index;
    item.n     <= eff_n;
    item.err   <= ({1'b0, linear_index} >= total);
    item.col   <= '0;
    item.start <= '0;
  end

endmodule

[sv/tri_rc_step.sv]
// ----------------------------------------------------------------------------
// tri_rc_step
// One binary search stage: decides one bit of the column number.
// ----------------------------------------------------------------------------
module tri_rc_step
  import tri_rc_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic  clk,
  input  logic  rst,
  input  item_t in_item,
  output item_t out_item
);

  logic [SIZE_W-1:0]   cand;
  logic [SIZE_W:0]     span;
  logic [2*SIZE_W:0]   prod;
  logic [SUM_W-1:0]    cand_start;
  logic                fits;
  logic                take;

  // trial column with this bit set
  assign cand = in_item.col | (SIZE_W'(1) << BIT);
  // column must be a real one, below n-1
  assign fits = ({1'b0, cand} + (SIZE_W+1)'(1)) < {1'b0, in_item.n};
  // first index of the trial column: cand*(2n-1-cand)/2
  assign span = {in_item.n, 1'b0} - (SIZE_W+1)'(1) - {1'b0, cand};
  assign prod = cand * span;
  assign cand_start = prod[SUM_W:1];
  assign take = fits && (cand_start <= {1'b0, in_item.idx});

  // advance the word, keeping the trial column when it does not pass the index
  always_ff @(posedge clk) begin
    if (rst) begin
      out_item.valid <= 1'b0;
    end else begin
      out_item.valid <= in_item.valid;
    end
    out_item.err <= in_item.err;
    out_item.idx <= in_item.idx;
    out_item.n   <= in_item.n;
    if (take) begin
      out_item.col   <= cand;
      out_item.start <= cand_start;
    end else begin
      out_item.col   <= in_item.col;
      out_item.start <= in_item.start;
    end
  end

endmodule

[sv/tri_rc_back.sv]
// ----------------------------------------------------------------------------
// tri_rc_back
// Output stage: forms the row from the found column and drives the result.
// ----------------------------------------------------------------------------
module tri_rc_back
  import tri_rc_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  item_t            in_item,
  output logic             done,
  output logic [OUT_W-1:0] row_index,
  output logic [OUT_W-1:0] col_index,
  output logic             out_of_range
);

  logic [SUM_W-1:0]  offset;
  logic [SIZE_W-1:0] row;

  // row = column + 1 + offset within the column
  assign offset = {1'b0, in_item.idx} - in_item.start;
  assign row    = in_item.col + SIZE_W'(1) + offset[SIZE_W-1:0];

  // drive the result word, zeroed on error
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= in_item.valid;
    end
    out_of_range <= in_item.err;
    if (in_item.err) begin
      row_index <= '0;
      col_index <= '0;
    end else begin
      row_index <= row[OUT_W-1:0];
      col_index <= in_item.col[OUT_W-1:0];
    end
  end

  // a valid element lies strictly below the diagonal
  assert property (@(posedge clk) disable iff (rst)
    in_item.valid && !in_item.err |-> row > in_item.col)
    else $error("row not below diagonal");

  // a valid element lies inside the matrix
  assert property (@(posedge clk) disable iff (rst)
    in_item.valid && !in_item.err |-> row < in_item.n)
    else $error("row beyond matrix");

endmodule

[sv/triangular_index_to_row_col_unit.sv]
// ----------------------------------------------------------------------------
// triangular_index_to_row_col_unit
// Maps a column-major strictly-lower-triangle index to its row and column.
// ----------------------------------------------------------------------------
// Stages: entry, then the binary search, then output; CW = clog2(min(MAX_ROWS, 2047)) column bits.
// Throughput: one word per cycle outside reset; one pipeline stage per column-number bit,
// each with one multiplier, sets the depth.
// busy is high only during reset; the receiver cannot stall, so done pulses.
// Reset clears all valid bits and sets the matrix size to 2.
// ----------------------------------------------------------------------------
module triangular_index_to_row_col_unit
  import tri_rc_pkg::*;
#(
  parameter int MAX_ROWS = 1024
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_wr_en,
  input  logic [SIZE_W-1:0] matrix_size,
  input  logic              start,
  output logic              busy,
  input  logic [IDX_W-1:0]  linear_index,
  output logic              done,
  output logic [OUT_W-1:0]  row_index,
  output logic [OUT_W-1:0]  col_index,
  output logic              out_of_range
);

  localparam int EFF_MAX = (MAX_ROWS < SIZE_MAX) ? MAX_ROWS : SIZE_MAX;
  localparam int CW      = $clog2(EFF_MAX);
  localparam int LAT     = CW + 2;

  item_t stage [CW+1];
  logic  accept;

  // take a word in every cycle outside reset
  assign busy   = rst;
  assign accept = start && !busy;

  tri_rc_front #(
    .MAX_ROWS(MAX_ROWS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .matrix_size  (matrix_size),
    .accept       (accept),
    .linear_index (linear_index),
    .item         (stage[0])
  );

  // search the column number from its top bit down
  for (genvar k = 0; k < CW; k++) begin : g_step
    tri_rc_step #(
      .BIT(CW - 1 - k)
    ) u_step (
      .clk      (clk),
      .rst      (rst),
      .in_item  (stage[k]),
      .out_item (stage[k+1])
    );
  end

  tri_rc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .in_item      (stage[CW]),
    .done         (done),
    .row_index    (row_index),
    .col_index    (col_index),
    .out_of_range (out_of_range)
  );

  // every accepted word comes out after the fixed latency
  assert property (@(posedge clk) disable iff (rst)
    accept |-> ##LAT done)
    else $error("result missing after pipeline latency");

  // no result without a word accepted the fixed latency earlier
  assert property (@(posedge clk) disable iff (rst)
    done && !$past(rst, LAT) |-> $past(accept, LAT))
    else $error("result without accepted word");

  // an out-of-range result carries zero row and column
  assert property (@(posedge clk) disable iff (rst)
    done && out_of_range |-> row_index == '0 && col_index == '0)
    else $error("error result with nonzero position");

endmodule
